/* design/hss_pkg.sv */
// Shared types, constants and helpers of the horizontal speckle suppressor.
// Used by hss_lane, hss_out_queue and the core; depends on nothing.
package hss_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_ROWS    = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int CFG_W       = 13;
   localparam int NUM_LANES   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam logic [7:0] THRESHOLD_RESET = 8'd30;
   localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(320);
   localparam logic [CFG_W-1:0] ROWS_RESET  = CFG_W'(240);

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH      = 2'd0,
      CSR_ROW_COUNT       = 2'd1,
      CSR_FOUR_CHANNEL    = 2'd2,
      CSR_LIGHT_THRESHOLD = 2'd3
   } csr_index_type;

   // Excess of own byte is own - (x + y) / 2.
   typedef struct packed {
      logic [7:0] own;
      logic [7:0] x;
      logic [7:0] y;
   } lane_operand_type;

   typedef struct packed {
      logic        frame_end;
      logic        row_end;
      logic        last;
      logic [31:0] data;
   } hss_entry_type;

   function automatic lane_operand_type lane_operand(input logic [31:0] p,
                                                     input logic [1:0]  k,
                                                     input logic        four);
      logic [7:0] v0, v1, v2, v3;
      logic [8:0] s12, s03;
      lane_operand_type op;
      v0  = p[7:0];
      v1  = p[15:8];
      v2  = p[23:16];
      v3  = p[31:24];
      s12 = {1'b0, v1} + {1'b0, v2};
      s03 = {1'b0, v0} + {1'b0, v3};
      case (k)
         2'd0:    op = four ? lane_operand_type'{v0, s12[8:1], v3}
                            : lane_operand_type'{v0, v1, v2};
         2'd1:    op = four ? lane_operand_type'{v1, v0, v3}
                            : lane_operand_type'{v1, v0, v2};
         2'd2:    op = four ? lane_operand_type'{v2, v0, v3}
                            : lane_operand_type'{v2, v0, v1};
         default: op = lane_operand_type'{v3, s12[8:1], v0};
      endcase
      return op;
   endfunction

   // Last valid index for a size register clamped to 1..maxv.
   function automatic logic [31:0] last_index(input logic [CFG_W-1:0] v, input int maxv);
      logic [31:0] r;
      if (v == '0) r = 32'd0;
      else if (32'(v) > 32'(maxv)) r = 32'(maxv) - 32'd1;
      else r = 32'(v) - 32'd1;
      return r;
   endfunction

endpackage

/* design/hss_lane.sv */
// One channel lane: compares the center excess against neighbors plus threshold.
// Depends on hss_pkg.
module hss_lane (
   input  hss_pkg::lane_operand_type prev_op,
   input  hss_pkg::lane_operand_type mid_op,
   input  hss_pkg::lane_operand_type next_op,
   input  logic [7:0]                threshold,
   output logic [7:0]                result
);
   import hss_pkg::*;

   function automatic logic signed [9:0] excess_of(input lane_operand_type op);
      logic [8:0] s;
      s = {1'b0, op.x} + {1'b0, op.y};
      return $signed({2'b00, op.own}) - $signed({2'b00, s[8:1]});
   endfunction

   logic signed [9:0]  ex_prev, ex_mid, ex_next;
   logic signed [11:0] limit;
   logic [8:0]         pair_sum;

   always_comb begin
      ex_prev  = excess_of(prev_op);
      ex_mid   = excess_of(mid_op);
      ex_next  = excess_of(next_op);
      limit    = $signed({4'b0000, threshold}) + $signed({{2{ex_prev[9]}}, ex_prev})
               + $signed({{2{ex_next[9]}}, ex_next});
      pair_sum = {1'b0, prev_op.own} + {1'b0, next_op.own};
      result   = ($signed({{2{ex_mid[9]}}, ex_mid}) > limit) ? pair_sum[8:1] : mid_op.own;
   end

endmodule

/* design/hss_out_queue.sv */
// Result queue: takes up to two entries per cycle, delivers one per transfer.
// Depends on hss_pkg.
module hss_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  hss_pkg::hss_entry_type push0,
   input  hss_pkg::hss_entry_type push1,
   output logic                  room,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output hss_pkg::hss_entry_type pop_entry
);
   import hss_pkg::*;

   hss_entry_type     q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              pop;

   always_comb begin
      room      = count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
      pop_valid = count_ff != '0;
      pop_entry = q_ff[rp_ff];
      pop       = pop_valid && pop_ready;
      wp_in     = wp_ff + QPTR_W'(push_count);
      rp_in     = rp_ff + QPTR_W'(pop);
      count_in  = count_ff + (QPTR_W+1)'(push_count) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) q_ff[wp_ff] <= push0;
      if (push_count == 2'd2) q_ff[QPTR_W'(wp_ff + 1'b1)] <= push1;
   end

endmodule

/* design/horizontal_speckle_suppressor_core.sv */
// Horizontal speckle suppressor: four channel lanes filter the held pixel
// against its row neighbors and one output queue merges the results.
// Depends on hss_pkg, hss_lane and hss_out_queue.
//
// Takes one pixel per clock while req_tready is high. The first pixel of a row of two
// or more pixels releases nothing; the results that a pixel releases are written
// to the output queue when it is accepted. A row's last pixel releases two results
// (one when the row is a single pixel), the second offered after the first, so a
// row yields as many results as it has pixels. The queue holds four results;
// req_tready drops while fewer than two places are free.
module horizontal_speckle_suppressor_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // ch0, ch1, ch2, ch3
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // out0, out1, out2, out3
   output logic [1:0]                rsp_tuser,   // row_end, frame_end
   output logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [hss_pkg::CFG_W-1:0] csr_wdata
);
   import hss_pkg::*;

   logic [CFG_W-1:0] line_width_ff, row_count_ff;
   logic             four_channel_ff;
   logic [7:0]       light_threshold_ff;

   logic [31:0]      left_pixel_ff, held_pixel_ff;
   logic [COL_W-1:0] column_ff, column_in, col_last;
   logic [ROW_W-1:0] row_ff, row_in, row_last_idx;

   logic             accept, row_last, frame_last, room;
   logic [31:0]      cur, held_masked, filtered, held_out;
   logic [7:0]       lane_byte [NUM_LANES];
   logic [1:0]       push_count;
   hss_entry_type    e0, e1, e_hold, e_cur, rsp_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff      <= WIDTH_RESET;
         row_count_ff       <= ROWS_RESET;
         four_channel_ff    <= 1'b0;
         light_threshold_ff <= THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH:      line_width_ff      <= csr_wdata;
            CSR_ROW_COUNT:       row_count_ff       <= csr_wdata;
            CSR_FOUR_CHANNEL:    four_channel_ff    <= csr_wdata[0];
            CSR_LIGHT_THRESHOLD: light_threshold_ff <= csr_wdata[7:0];
         endcase
      end
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      hss_lane u_lane (
         .prev_op   (lane_operand(left_pixel_ff, 2'(k), four_channel_ff)),
         .mid_op    (lane_operand(held_pixel_ff, 2'(k), four_channel_ff)),
         .next_op   (lane_operand(cur, 2'(k), four_channel_ff)),
         .threshold (light_threshold_ff),
         .result    (lane_byte[k])
      );
   end

   always_comb begin
      accept       = req_tvalid && req_tready;
      col_last     = COL_W'(last_index(line_width_ff, MAX_WIDTH));
      row_last_idx = ROW_W'(last_index(row_count_ff, MAX_ROWS));
      cur          = {four_channel_ff ? req_tdata[31:24] : 8'd0, req_tdata[23:0]};
      row_last     = column_ff >= col_last;
      frame_last   = row_last && (row_ff >= row_last_idx);
      held_masked  = {four_channel_ff ? held_pixel_ff[31:24] : 8'd0, held_pixel_ff[23:0]};
      filtered     = {four_channel_ff ? lane_byte[3] : 8'd0,
                      lane_byte[2], lane_byte[1], lane_byte[0]};
      held_out     = (column_ff == COL_W'(1)) ? held_masked : filtered;
      e_hold       = '{frame_end: 1'b0, row_end: 1'b0, last: !row_last, data: held_out};
      e_cur        = '{frame_end: frame_last, row_end: 1'b1, last: 1'b1, data: cur};
      if (column_ff != '0) begin
         e0         = e_hold;
         push_count = row_last ? 2'd2 : 2'd1;
      end else begin
         e0         = e_cur;
         push_count = row_last ? 2'd1 : 2'd0;
      end
      e1 = e_cur;
      if (!accept) push_count = 2'd0;
      column_in = row_last ? '0 : COL_W'(column_ff + 1'b1);
      if (!row_last) row_in = row_ff;
      else if (frame_last) row_in = '0;
      else row_in = ROW_W'(row_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_pixel_ff <= '0;
         held_pixel_ff <= '0;
         column_ff     <= '0;
         row_ff        <= '0;
      end else if (accept) begin
         left_pixel_ff <= held_pixel_ff;
         held_pixel_ff <= cur;
         column_ff     <= column_in;
         row_ff        <= row_in;
      end
   end

   hss_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (e0),
      .push1      (e1),
      .room       (room),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_entry  (rsp_entry)
   );

   always_comb begin
      req_tready = room;
      rsp_tdata  = rsp_entry.data;
      rsp_tuser  = {rsp_entry.frame_end, rsp_entry.row_end};
      rsp_tlast  = rsp_entry.last;
   end

endmodule

/* design/hss_checker.sv */
// Port-level checks for the speckle suppressor, bound to the top level.
// Depends on horizontal_speckle_suppressor_core.
module hss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not empty after reset");

   a_row_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("row end without last");

   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("frame end outside row end");

endmodule

bind horizontal_speckle_suppressor_core hss_checker u_hss_checker (.*);
